FILE: design/cbd_pkg.sv
// ----------------------------------------------------------------------------
// CPU bus decode package
// Shared types, address map constants and reset values for the CPU bus
// decoder with sprite DMA and audio sample pacing.
// ----------------------------------------------------------------------------
package cbd_pkg;

  localparam int unsigned RamBytes = 2048;
  localparam int unsigned RamAw    = $clog2(RamBytes);

  localparam logic [15:0] RamTop    = 16'h1FFF;
  localparam logic [15:0] PpuTop    = 16'h3FFF;
  localparam logic [15:0] ApuBase   = 16'h4000;
  localparam logic [15:0] ApuTop    = 16'h4013;
  localparam logic [15:0] DmaAddr   = 16'h4014;
  localparam logic [15:0] ApuStatus = 16'h4015;
  localparam logic [15:0] Pad0Addr  = 16'h4016;
  localparam logic [15:0] Pad1Addr  = 16'h4017;

  localparam logic [2:0] PhaseEven = 3'd0;
  localparam logic [2:0] PhaseOdd  = 3'd3;
  localparam logic [2:0] PhaseLast = 3'd5;

  localparam logic [22:0] ClockHz        = 23'd5369318;
  localparam logic [22:0] SampleRateInit = 23'd44100;

  typedef enum logic [1:0] {
    CmdWrite = 2'd0,
    CmdRead  = 2'd1,
    CmdTick  = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    RouteNone = 2'd0,
    RouteCart = 2'd1,
    RoutePpu  = 2'd2,
    RouteApu  = 2'd3
  } route_e;

  typedef struct packed {
    logic [7:0]  pad_shift0;
    logic [7:0]  pad_shift1;
    logic [7:0]  xfer_page;
    logic [7:0]  dma_offset;
    logic [7:0]  dma_byte;
    logic        dma_waiting;
    logic        dma_active;
    logic [2:0]  tick_phase;
    logic [22:0] audio_accum;
  } state_t;

  localparam state_t StateReset = '{
    pad_shift0:  8'h00,
    pad_shift1:  8'h00,
    xfer_page:   8'h00,
    dma_offset:  8'h00,
    dma_byte:    8'h00,
    dma_waiting: 1'b1,
    dma_active:  1'b0,
    tick_phase:  3'd0,
    audio_accum: 23'd0
  };

  typedef struct packed {
    logic [7:0]  read_data;
    logic        from_ram;
    logic [1:0]  route;
    logic [15:0] access_addr;
    logic        cpu_step;
    logic        oam_write;
    logic [7:0]  oam_index;
    logic [7:0]  oam_data;
    logic        sample_ready;
    logic        dma_busy;
  } result_t;

  typedef struct packed {
    logic             we;
    logic [RamAw-1:0] waddr;
    logic [7:0]       wdata;
    logic             re;
    logic [RamAw-1:0] raddr;
    logic             dma_fill;
  } ram_req_t;

endpackage

FILE: design/cpu_bus_decode_with_sprite_dma_core.sv
// ----------------------------------------------------------------------------
// CPU bus decode with sprite DMA
// Decodes CPU reads and writes, sequences sprite DMA and paces CPU steps
// and audio samples on master clock ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one item per beat: a CPU
//   write, a CPU read or one master clock tick, with the cartridge claim,
//   device read byte and both controller bytes for that beat.
//   Output channel (out_valid_o/out_ready_i) returns one result beat per
//   input beat, in order.
//   Config channel (cfg_valid_i/cfg_ready_o) writes the audio sample rate;
//   it is always ready.
//   Each result beat is registered and appears in the cycle after its input
//   beat is taken. Throughput is one beat per cycle while the receiver keeps
//   up: the result register frees up in the same cycle its beat is taken,
//   and work RAM reads are registered in line with it. After reset the work
//   RAM (2048 bytes) is zero filled, one byte per cycle; in_ready_o stays low
//   until the fill completes. When the receiver stalls, the result beat holds
//   and in_ready_o drops until it is taken.
// ----------------------------------------------------------------------------
module cpu_bus_decode_with_sprite_dma_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [22:0] audio_rate_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [15:0] addr_i,
  input  logic [7:0]  wdata_i,
  input  logic        cart_claims_i,
  input  logic [7:0]  device_rdata_i,
  input  logic [7:0]  pad0_i,
  input  logic [7:0]  pad1_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [1:0]  route_o,
  output logic [15:0] access_addr_o,
  output logic        cpu_step_o,
  output logic        oam_write_o,
  output logic [7:0]  oam_index_o,
  output logic [7:0]  oam_data_o,
  output logic        sample_ready_o,
  output logic        dma_busy_o
);

  logic              accept;
  logic              clr_busy;
  logic [7:0]        ram_rdata;
  logic [22:0]       audio_rate_q;
  logic              out_valid_q;
  logic              dma_fill_q;
  cbd_pkg::state_t   st_q;
  cbd_pkg::state_t   st_cur;
  cbd_pkg::state_t   st_d;
  cbd_pkg::result_t  res_q;
  cbd_pkg::result_t  res_d;
  cbd_pkg::ram_req_t ram_req;
  cbd_pkg::ram_req_t ram_dec;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !clr_busy && (!out_valid_q || out_ready_i);
  assign accept      = in_valid_i && in_ready_o;

  // Merge the DMA byte fetched from work RAM on the previous beat
  always_comb begin
    st_cur = st_q;
    if (dma_fill_q) begin
      st_cur.dma_byte = ram_rdata;
    end
  end

  cbd_decode u_decode (
    .command_i      (command_i),
    .addr_i         (addr_i),
    .wdata_i        (wdata_i),
    .cart_claims_i  (cart_claims_i),
    .device_rdata_i (device_rdata_i),
    .pad0_i         (pad0_i),
    .pad1_i         (pad1_i),
    .audio_rate_i   (audio_rate_q),
    .st_i           (st_cur),
    .st_o           (st_d),
    .res_o          (res_d),
    .ram_o          (ram_dec)
  );

  always_comb begin
    ram_req          = ram_dec;
    ram_req.we       = accept && ram_dec.we;
    ram_req.re       = accept && ram_dec.re;
    ram_req.dma_fill = accept && ram_dec.dma_fill;
  end

  cbd_work_ram u_work_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (ram_req),
    .rdata_o    (ram_rdata),
    .clr_busy_o (clr_busy)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      audio_rate_q <= cbd_pkg::SampleRateInit;
    end else if (cfg_valid_i && cfg_ready_o) begin
      audio_rate_q <= audio_rate_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= cbd_pkg::StateReset;
      dma_fill_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        st_q <= st_d;
      end else if (dma_fill_q) begin
        st_q <= st_cur;
      end
      dma_fill_q <= ram_req.dma_fill;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = res_q.from_ram ? ram_rdata : res_q.read_data;
  assign route_o        = res_q.route;
  assign access_addr_o  = res_q.access_addr;
  assign cpu_step_o     = res_q.cpu_step;
  assign oam_write_o    = res_q.oam_write;
  assign oam_index_o    = res_q.oam_index;
  assign oam_data_o     = res_q.oam_data;
  assign sample_ready_o = res_q.sample_ready;
  assign dma_busy_o     = res_q.dma_busy;

endmodule

FILE: design/cbd_work_ram.sv
// ----------------------------------------------------------------------------
// CPU work RAM
// Single write port, single registered read port, with a zero fill sweep
// that runs once after reset, one byte per cycle.
// ----------------------------------------------------------------------------
module cbd_work_ram (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cbd_pkg::ram_req_t         req_i,
  output logic [7:0]                rdata_o,
  output logic                      clr_busy_o
);

  logic [7:0]                mem [cbd_pkg::RamBytes];
  logic [cbd_pkg::RamAw-1:0] clr_cnt_q;
  logic                      clr_busy_q;
  logic [7:0]                rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + {{(cbd_pkg::RamAw-1){1'b0}}, 1'b1};
      if (&clr_cnt_q) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_cnt_q] <= 8'h00;
    end else if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o    = rdata_q;
  assign clr_busy_o = clr_busy_q;

endmodule

FILE: design/cbd_decode.sv
// ----------------------------------------------------------------------------
// CPU bus decode step
// Decodes one item against the current state: address routing, controller
// shift ports, sprite DMA sequencing, CPU slot pacing and audio pacing.
// ----------------------------------------------------------------------------
module cbd_decode (
  input  logic [1:0]         command_i,
  input  logic [15:0]        addr_i,
  input  logic [7:0]         wdata_i,
  input  logic               cart_claims_i,
  input  logic [7:0]         device_rdata_i,
  input  logic [7:0]         pad0_i,
  input  logic [7:0]         pad1_i,
  input  logic [22:0]        audio_rate_i,
  input  cbd_pkg::state_t    st_i,
  output cbd_pkg::state_t    st_o,
  output cbd_pkg::result_t   res_o,
  output cbd_pkg::ram_req_t  ram_o
);

  always_comb begin
    logic [15:0] xfer_addr;
    logic [15:0] a;
    logic        slot;
    logic        dma_rd;
    logic        do_rd;
    logic [7:0]  rd_val;
    logic [1:0]  rd_route;
    logic        rd_ram;
    logic [22:0] rate;
    logic [23:0] sum;

    st_o  = st_i;
    res_o = '0;
    ram_o = '0;

    xfer_addr = {st_i.xfer_page, st_i.dma_offset};
    slot     = (st_i.tick_phase == cbd_pkg::PhaseEven) ||
               (st_i.tick_phase == cbd_pkg::PhaseOdd);
    dma_rd   = (command_i == cbd_pkg::CmdTick) && slot && st_i.dma_active &&
               !st_i.dma_waiting && (st_i.tick_phase == cbd_pkg::PhaseEven);
    do_rd    = (command_i == cbd_pkg::CmdRead) || dma_rd;
    a        = (command_i == cbd_pkg::CmdTick) ? xfer_addr : addr_i;

    rd_val   = 8'h00;
    rd_route = cbd_pkg::RouteNone;
    rd_ram   = 1'b0;
    if (cart_claims_i) begin
      rd_route = cbd_pkg::RouteCart;
      rd_val   = device_rdata_i;
    end else if (a <= cbd_pkg::RamTop) begin
      rd_ram = 1'b1;
    end else if (a <= cbd_pkg::PpuTop) begin
      rd_route = cbd_pkg::RoutePpu;
      rd_val   = device_rdata_i;
    end else if (a == cbd_pkg::ApuStatus) begin
      rd_route = cbd_pkg::RouteApu;
      rd_val   = device_rdata_i;
    end else if (a == cbd_pkg::Pad0Addr) begin
      rd_val = {7'd0, st_i.pad_shift0[7]};
      if (do_rd) begin
        st_o.pad_shift0 = {st_i.pad_shift0[6:0], 1'b0};
      end
    end else if (a == cbd_pkg::Pad1Addr) begin
      rd_val = {7'd0, st_i.pad_shift1[7]};
      if (do_rd) begin
        st_o.pad_shift1 = {st_i.pad_shift1[6:0], 1'b0};
      end
    end

    ram_o.raddr = a[cbd_pkg::RamAw-1:0];
    ram_o.re    = do_rd && rd_ram;
    ram_o.waddr = addr_i[cbd_pkg::RamAw-1:0];
    ram_o.wdata = wdata_i;

    rate = (audio_rate_i > cbd_pkg::ClockHz) ? cbd_pkg::ClockHz : audio_rate_i;
    sum  = {1'b0, st_i.audio_accum} + {1'b0, rate};

    unique case (command_i)
      cbd_pkg::CmdWrite: begin
        res_o.access_addr = addr_i;
        if (cart_claims_i) begin
          res_o.route = cbd_pkg::RouteCart;
        end else if (addr_i <= cbd_pkg::RamTop) begin
          ram_o.we = 1'b1;
        end else if (addr_i <= cbd_pkg::PpuTop) begin
          res_o.route = cbd_pkg::RoutePpu;
        end else if ((addr_i >= cbd_pkg::ApuBase && addr_i <= cbd_pkg::ApuTop) ||
                     addr_i == cbd_pkg::ApuStatus || addr_i == cbd_pkg::Pad1Addr) begin
          res_o.route = cbd_pkg::RouteApu;
        end else if (addr_i == cbd_pkg::DmaAddr) begin
          st_o.xfer_page  = wdata_i;
          st_o.dma_offset = 8'h00;
          st_o.dma_active = 1'b1;
        end else if (addr_i == cbd_pkg::Pad0Addr) begin
          st_o.pad_shift0 = pad0_i;
          st_o.pad_shift1 = pad1_i;
        end
      end
      cbd_pkg::CmdRead: begin
        res_o.access_addr = addr_i;
        res_o.read_data   = rd_val;
        res_o.route       = rd_route;
        res_o.from_ram    = rd_ram;
      end
      cbd_pkg::CmdTick: begin
        res_o.access_addr = xfer_addr;
        if (slot) begin
          if (!st_i.dma_active) begin
            res_o.cpu_step = 1'b1;
          end else if (st_i.dma_waiting) begin
            if (st_i.tick_phase == cbd_pkg::PhaseOdd) begin
              st_o.dma_waiting = 1'b0;
            end
          end else if (st_i.tick_phase == cbd_pkg::PhaseEven) begin
            res_o.route = rd_route;
            if (rd_ram) begin
              ram_o.dma_fill = 1'b1;
            end else begin
              st_o.dma_byte = rd_val;
            end
          end else begin
            res_o.oam_write = 1'b1;
            res_o.oam_index = st_i.dma_offset;
            res_o.oam_data  = st_i.dma_byte;
            st_o.dma_offset = st_i.dma_offset + 8'd1;
            if (&st_i.dma_offset) begin
              st_o.dma_active  = 1'b0;
              st_o.dma_waiting = 1'b1;
            end
          end
        end
        st_o.tick_phase = (st_i.tick_phase >= cbd_pkg::PhaseLast) ? 3'd0
                                                                  : st_i.tick_phase + 3'd1;
        if (sum >= {1'b0, cbd_pkg::ClockHz}) begin
          sum                = sum - {1'b0, cbd_pkg::ClockHz};
          res_o.sample_ready = 1'b1;
        end
        st_o.audio_accum = sum[22:0];
      end
      default: begin
      end
    endcase

    res_o.dma_busy = st_o.dma_active;
  end

endmodule

FILE: test/tb_cpu_bus_decode_with_sprite_dma_core.sv
// ----------------------------------------------------------------------------
// CPU bus decode with sprite DMA testbench
// Drives CPU writes, CPU reads and master clock ticks through the input
// channel and checks each result beat against a pinned table row or an in-bench
// model of the address decode, controller shifters, sprite DMA sequencing and
// audio pacing. A short opening table covers the address map corners; random
// phases follow with different sample rates and idle patterns on both sides.
// ----------------------------------------------------------------------------
module tb_cpu_bus_decode_with_sprite_dma_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CmdUnknown    = 2'd3;
  localparam logic [1:0] CmdWr         = cbd_pkg::CmdWrite;
  localparam logic [1:0] CmdRd         = cbd_pkg::CmdRead;
  localparam logic [1:0] CmdTk         = cbd_pkg::CmdTick;
  localparam cbd_pkg::route_e RtNone   = cbd_pkg::RouteNone;
  localparam cbd_pkg::route_e RtCart   = cbd_pkg::RouteCart;
  localparam cbd_pkg::route_e RtPpu    = cbd_pkg::RoutePpu;
  localparam cbd_pkg::route_e RtApu    = cbd_pkg::RouteApu;
  localparam int         WatchdogLimit = 20000;
  localparam int         PhaseCount    = 8;
  localparam int         PhaseBeats    = 225;
  localparam int         OpeningRows   = 26;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  wdata;
    logic        claim;
    logic [7:0]  dev;
    logic [7:0]  pad0;
    logic [7:0]  pad1;
  } bus_item_t;

  typedef struct packed {
    logic [7:0]      read_data;
    cbd_pkg::route_e route;
    logic [15:0]     access_addr;
    logic            cpu_step;
    logic            oam_write;
    logic [7:0]      oam_index;
    logic [7:0]      oam_data;
    logic            sample_ready;
    logic            dma_busy;
  } bus_result_t;

  typedef struct packed {
    bus_item_t       item;
    logic            pin;
    logic [7:0]      rd;
    cbd_pkg::route_e rt;
  } opening_row_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [22:0] audio_rate_i  = '0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [1:0]  command_i     = '0;
  logic [15:0] addr_i        = '0;
  logic [7:0]  wdata_i       = '0;
  logic        cart_claims_i = 1'b0;
  logic [7:0]  device_rdata_i = '0;
  logic [7:0]  pad0_i        = '0;
  logic [7:0]  pad1_i        = '0;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [7:0]  read_data_o;
  logic [1:0]  route_o;
  logic [15:0] access_addr_o;
  logic        cpu_step_o;
  logic        oam_write_o;
  logic [7:0]  oam_index_o;
  logic [7:0]  oam_data_o;
  logic        sample_ready_o;
  logic        dma_busy_o;

  cpu_bus_decode_with_sprite_dma_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .audio_rate_i   (audio_rate_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .addr_i         (addr_i),
    .wdata_i        (wdata_i),
    .cart_claims_i  (cart_claims_i),
    .device_rdata_i (device_rdata_i),
    .pad0_i         (pad0_i),
    .pad1_i         (pad1_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .read_data_o    (read_data_o),
    .route_o        (route_o),
    .access_addr_o  (access_addr_o),
    .cpu_step_o     (cpu_step_o),
    .oam_write_o    (oam_write_o),
    .oam_index_o    (oam_index_o),
    .oam_data_o     (oam_data_o),
    .sample_ready_o (sample_ready_o),
    .dma_busy_o     (dma_busy_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Model state
  logic [7:0]  ram_m [cbd_pkg::RamBytes];
  logic [7:0]  pad_m [2];
  logic [7:0]  xfer_page_m;
  logic [7:0]  dma_off_m;
  logic [7:0]  dma_byte_m;
  logic        dma_wait_m;
  logic        dma_active_m;
  logic [2:0]  phase_m;
  logic [22:0] accum_m;
  logic [22:0] rate_m;

  bus_result_t results_due [$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned stall_pct      = 0;

  opening_row_t opening_rows [OpeningRows] = '{
    //   cmd         addr      wd     cl    dev    pad0   pad1    pin   rd     route
    '{'{CmdRd,      16'h0000, 8'h00, 1'b0, 8'hA5, 8'h00, 8'h00}, 1'b1, 8'h00, RtNone},
    '{'{CmdRd,      16'hFFFF, 8'h00, 1'b0, 8'hAB, 8'h00, 8'h00}, 1'b1, 8'h00, RtNone},
    '{'{CmdRd,      16'hFFFF, 8'h00, 1'b1, 8'hFF, 8'h00, 8'h00}, 1'b1, 8'hFF, RtCart},
    '{'{CmdWr,      16'h0000, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00, RtNone},
    '{'{CmdWr,      16'h1FFF, 8'h5A, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00, RtNone},
    '{'{CmdRd,      16'h07FF, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdRd,      16'h1800, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdWr,      16'h2000, 8'h12, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00, RtPpu},
    '{'{CmdRd,      16'h3FFF, 8'h00, 1'b0, 8'h3C, 8'h00, 8'h00}, 1'b1, 8'h3C, RtPpu},
    '{'{CmdWr,      16'h4000, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00, RtApu},
    '{'{CmdWr,      16'h4013, 8'hFF, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00, RtApu},
    '{'{CmdRd,      16'h4015, 8'h00, 1'b0, 8'h81, 8'h00, 8'h00}, 1'b1, 8'h81, RtApu},
    '{'{CmdRd,      16'h4013, 8'h00, 1'b0, 8'h77, 8'h00, 8'h00}, 1'b1, 8'h00, RtNone},
    '{'{CmdWr,      16'h4016, 8'h00, 1'b0, 8'h00, 8'h80, 8'h01}, 1'b0, 8'h00, RtNone},
    '{'{CmdRd,      16'h4016, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdRd,      16'h4017, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdWr,      16'h4017, 8'h00, 1'b0, 8'h00, 8'hFF, 8'hFF}, 1'b1, 8'h00, RtApu},
    '{'{CmdRd,      16'h4016, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdWr,      16'h5000, 8'h33, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00, RtNone},
    '{'{CmdWr,      16'hFFFF, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00}, 1'b1, 8'h00, RtCart},
    '{'{CmdUnknown, 16'hFFFF, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF}, 1'b0, 8'h00, RtNone},
    '{'{CmdTk,      16'h0000, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdWr,      16'h4014, 8'h02, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdTk,      16'h0000, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdWr,      16'h4014, 8'h40, 1'b0, 8'h00, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone},
    '{'{CmdTk,      16'h0000, 8'h00, 1'b1, 8'hC3, 8'h00, 8'h00}, 1'b0, 8'h00, RtNone}
  };

  function automatic logic [7:0] bus_read_effect(logic [15:0] a, logic claim,
                                                 logic [7:0] dev,
                                                 output cbd_pkg::route_e rt);
    logic [7:0] v;
    rt = RtNone;
    v  = 8'h00;
    if (claim) begin
      rt = RtCart;
      v  = dev;
    end else if (a <= cbd_pkg::RamTop) begin
      v = ram_m[a[cbd_pkg::RamAw-1:0]];
    end else if (a <= cbd_pkg::PpuTop) begin
      rt = RtPpu;
      v  = dev;
    end else if (a == cbd_pkg::ApuStatus) begin
      rt = RtApu;
      v  = dev;
    end else if (a == cbd_pkg::Pad0Addr || a == cbd_pkg::Pad1Addr) begin
      v = {7'd0, pad_m[a[0]][7]};
      pad_m[a[0]] = pad_m[a[0]] << 1;
    end
    return v;
  endfunction

  function automatic bus_result_t predict_bus_beat(bus_item_t s);
    bus_result_t     r;
    cbd_pkg::route_e rt;
    logic [2:0]      ph;
    logic [22:0]     rate;
    logic [23:0]     sum;
    r = '0;
    case (s.cmd)
      CmdWr: begin
        r.access_addr = s.addr;
        if (s.claim) begin
          r.route = RtCart;
        end else if (s.addr <= cbd_pkg::RamTop) begin
          ram_m[s.addr[cbd_pkg::RamAw-1:0]] = s.wdata;
        end else if (s.addr <= cbd_pkg::PpuTop) begin
          r.route = RtPpu;
        end else if ((s.addr >= cbd_pkg::ApuBase && s.addr <= cbd_pkg::ApuTop) ||
                     s.addr == cbd_pkg::ApuStatus || s.addr == cbd_pkg::Pad1Addr) begin
          r.route = RtApu;
        end else if (s.addr == cbd_pkg::DmaAddr) begin
          xfer_page_m  = s.wdata;
          dma_off_m    = 8'h00;
          dma_active_m = 1'b1;
        end else if (s.addr == cbd_pkg::Pad0Addr) begin
          pad_m[0] = s.pad0;
          pad_m[1] = s.pad1;
        end
      end
      CmdRd: begin
        r.access_addr = s.addr;
        r.read_data   = bus_read_effect(s.addr, s.claim, s.dev, rt);
        r.route       = rt;
      end
      CmdTk: begin
        ph = phase_m;
        r.access_addr = {xfer_page_m, dma_off_m};
        if (ph == cbd_pkg::PhaseEven || ph == cbd_pkg::PhaseOdd) begin
          if (!dma_active_m) begin
            r.cpu_step = 1'b1;
          end else if (dma_wait_m) begin
            if (ph == cbd_pkg::PhaseOdd) dma_wait_m = 1'b0;
          end else if (ph == cbd_pkg::PhaseEven) begin
            dma_byte_m = bus_read_effect(r.access_addr, s.claim, s.dev, rt);
            r.route    = rt;
          end else begin
            r.oam_write = 1'b1;
            r.oam_index = dma_off_m;
            r.oam_data  = dma_byte_m;
            dma_off_m   = dma_off_m + 8'd1;
            if (dma_off_m == 8'h00) begin
              dma_active_m = 1'b0;
              dma_wait_m   = 1'b1;
            end
          end
        end
        phase_m = (ph >= cbd_pkg::PhaseLast) ? 3'd0 : ph + 3'd1;
        rate = (rate_m > cbd_pkg::ClockHz) ? cbd_pkg::ClockHz : rate_m;
        sum  = {1'b0, accum_m} + {1'b0, rate};
        if (sum >= {1'b0, cbd_pkg::ClockHz}) begin
          sum            = sum - {1'b0, cbd_pkg::ClockHz};
          r.sample_ready = 1'b1;
        end
        accum_m = sum[22:0];
      end
      default: ;
    endcase
    r.dma_busy = dma_active_m;
    return r;
  endfunction

  function automatic logic [15:0] random_addr();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 35) return 16'($urandom_range(0, cbd_pkg::RamTop));
    if (r < 50) return 16'($urandom_range(cbd_pkg::RamTop + 16'd1, cbd_pkg::PpuTop));
    if (r < 80) return 16'($urandom_range(cbd_pkg::ApuBase, cbd_pkg::ApuBase + 16'h001F));
    if (r < 90) return 16'($urandom_range(cbd_pkg::Pad0Addr, cbd_pkg::Pad1Addr));
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Mostly ticks while DMA runs so a transfer finishes; start new ones when idle.
  function automatic bus_item_t random_item();
    bus_item_t   it;
    int unsigned pick;
    it.addr  = random_addr();
    it.wdata = 8'($urandom);
    it.claim = ($urandom_range(3) == 0);
    it.dev   = 8'($urandom);
    it.pad0  = 8'($urandom);
    it.pad1  = 8'($urandom);
    pick = $urandom_range(999);
    if (dma_active_m) begin
      if (pick < 940) it.cmd = CmdTk;
      else if (pick < 970) it.cmd = CmdRd;
      else it.cmd = CmdWr;
      if (it.cmd == CmdWr && it.addr == cbd_pkg::DmaAddr) it.addr = cbd_pkg::ApuBase;
    end else begin
      if (pick < 400) it.cmd = CmdTk;
      else if (pick < 700) it.cmd = CmdRd;
      else it.cmd = CmdWr;
      if (pick >= 990) begin
        it.cmd  = CmdWr;
        it.addr = cbd_pkg::DmaAddr;
      end
    end
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic send_bus_beat(bus_item_t s, logic pin, bus_result_t pin_res);
    bus_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= s.cmd;
    addr_i         <= s.addr;
    wdata_i        <= s.wdata;
    cart_claims_i  <= s.claim;
    device_rdata_i <= s.dev;
    pad0_i         <= s.pad0;
    pad1_i         <= s.pad1;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_bus_beat(s);
    results_due.push_back(pin ? pin_res : r);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_sample_rate(logic [22:0] v);
    cfg_valid_i  <= 1'b1;
    audio_rate_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    rate_m = v;
  endtask

  always @(posedge clk_i) begin : check_results
    bus_result_t want;
    int unsigned quiet_cycles;
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = results_due.pop_front();
        check_field("read_data", 16'(read_data_o), 16'(want.read_data));
        check_field("route", 16'(route_o), 16'(want.route));
        check_field("access_addr", access_addr_o, want.access_addr);
        check_field("cpu_step", 16'(cpu_step_o), 16'(want.cpu_step));
        check_field("oam_write", 16'(oam_write_o), 16'(want.oam_write));
        check_field("oam_index", 16'(oam_index_o), 16'(want.oam_index));
        check_field("oam_data", 16'(oam_data_o), 16'(want.oam_data));
        check_field("sample_ready", 16'(sample_ready_o), 16'(want.sample_ready));
        check_field("dma_busy", 16'(dma_busy_o), 16'(want.dma_busy));
      end
    end
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    bus_result_t pin_res;
    logic [22:0] rates [PhaseCount];
    int unsigned send_pcts [4];
    int unsigned stall_pcts [4];
    send_pcts  = '{0, 60, 0, 33};
    stall_pcts = '{0, 0, 60, 33};
    rates = '{cbd_pkg::ClockHz, cbd_pkg::SampleRateInit,
              23'($urandom_range(1, cbd_pkg::ClockHz)), 23'd1,
              23'($urandom_range(1, cbd_pkg::ClockHz)), 23'd48000,
              23'($urandom_range(1, cbd_pkg::ClockHz)), 23'h7FFFFF};
    foreach (ram_m[i]) ram_m[i] = 8'h00;
    pad_m[0]     = 8'h00;
    pad_m[1]     = 8'h00;
    xfer_page_m  = cbd_pkg::StateReset.xfer_page;
    dma_off_m    = cbd_pkg::StateReset.dma_offset;
    dma_byte_m   = cbd_pkg::StateReset.dma_byte;
    dma_wait_m   = cbd_pkg::StateReset.dma_waiting;
    dma_active_m = cbd_pkg::StateReset.dma_active;
    phase_m      = cbd_pkg::StateReset.tick_phase;
    accum_m      = cbd_pkg::StateReset.audio_accum;
    rate_m       = cbd_pkg::SampleRateInit;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    write_sample_rate(23'd1);

    for (int i = 0; i < OpeningRows; i++) begin
      pin_res             = '0;
      pin_res.read_data   = opening_rows[i].rd;
      pin_res.route       = opening_rows[i].rt;
      pin_res.access_addr = opening_rows[i].item.addr;
      send_bus_beat(opening_rows[i].item, opening_rows[i].pin, pin_res);
    end

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      write_sample_rate(rates[p]);
      send_idle_pct = send_pcts[p % 4];
      stall_pct     = stall_pcts[p % 4];
      for (int n = 0; n < PhaseBeats; n++) send_bus_beat(random_item(), 1'b0, '0);
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
